/* rtl/crc32c_block_folder_top_macros.svh */
// Assertion macros for the CRC32C block folder
`ifndef CRC32C_BLOCK_FOLDER_TOP_MACROS_SVH
`define CRC32C_BLOCK_FOLDER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define CBF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cbf_pkg.sv */
// Package: types, folding constants and carry-less product for the CRC32C block folder
package cbf_pkg;

  localparam logic [63:0] K5    = 64'h0000_0000_F20C_0DFE;
  localparam logic [63:0] K6    = 64'h0000_0001_4CD0_0BD6;
  localparam logic [63:0] K7    = 64'h0000_0000_DD45_AAB8;
  localparam logic [63:0] P1    = 64'h0000_0001_05EC_76F0;
  localparam logic [63:0] P2    = 64'h0000_0000_DEA7_13F1;
  localparam logic [63:0] LOW32 = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [63:0] blk_lo;
    logic [63:0] blk_hi;
    logic        first;
    logic        last;
  } cbf_item_t;

  typedef struct packed {
    logic idle;
    logic reducing;
  } cbf_back_stat_t;

  // 64 x 64 -> 128 carry-less product
  function automatic logic [127:0] clmul64(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (b[i]) begin
        r = r ^ ({64'd0, a} << i);
      end
    end
    return r;
  endfunction

endpackage

/* rtl/cbf_front.sv */
// Front end: accepts blocks, merges the starting CRC into first blocks
module cbf_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [63:0]       in_data_low_word,
  input  logic [63:0]       in_data_high_word,
  input  logic [31:0]       in_initial_crc,
  input  logic              in_first_block,
  input  logic              in_last_block,
  input  logic              q_full,
  output logic              q_push,
  output cbf_pkg::cbf_item_t q_item
);
  import cbf_pkg::*;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.blk_lo = in_first_block ? (in_data_low_word ^ {32'd0, in_initial_crc})
                                   : in_data_low_word;
    q_item.blk_hi = in_data_high_word;
    q_item.first  = in_first_block;
    q_item.last   = in_last_block;
  end

endmodule

/* rtl/cbf_fifo.sv */
// Short item queue between front and back ends
module cbf_fifo #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cbf_pkg::cbf_item_t push_item,
  input  logic               pop,
  output cbf_pkg::cbf_item_t head_item,
  output logic               full,
  output logic               empty
);
  import cbf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cbf_item_t     mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign empty     = (cnt_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/cbf_back.sv */
// Back end: 128-bit fold accumulator, staged reduction and result register
module cbf_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cbf_pkg::cbf_item_t      head_item,
  input  logic                    q_empty,
  output logic                    q_pop,
  output cbf_pkg::cbf_back_stat_t stat,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [31:0]             out_crc_out
);
  import cbf_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RED1 = 3'd1;
  localparam logic [2:0] ST_RED2 = 3'd2;
  localparam logic [2:0] ST_RED3 = 3'd3;
  localparam logic [2:0] ST_RED4 = 3'd4;

  logic [2:0]   state_r, state_nxt;
  logic [63:0]  acc_lo_r, acc_lo_nxt;
  logic [63:0]  acc_hi_r, acc_hi_nxt;
  logic [63:0]  r_lo_r, r_lo_nxt;
  logic [63:0]  r_hi_r, r_hi_nxt;
  logic [31:0]  t_r, t_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [31:0]  out_crc_r, out_crc_nxt;
  logic [127:0] prod_a, prod_b, prod_r;
  logic [63:0]  s_lo, s_hi;
  logic         out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_crc_out = out_crc_r;
  assign stat.idle     = (state_r == ST_IDLE);
  assign stat.reducing = (state_r != ST_IDLE);

  // fold products
  assign prod_a = clmul64(acc_lo_r, K5);
  assign prod_b = clmul64(acc_hi_r, K6);

  assign s_lo = {r_hi_r[31:0], r_lo_r[63:32]};
  assign s_hi = {32'd0, r_hi_r[63:32]};

  always_comb begin
    state_nxt     = state_r;
    acc_lo_nxt    = acc_lo_r;
    acc_hi_nxt    = acc_hi_r;
    r_lo_nxt      = r_lo_r;
    r_hi_nxt      = r_hi_r;
    t_nxt         = t_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_crc_nxt   = out_crc_r;
    prod_r        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (head_item.first) begin
            acc_lo_nxt = head_item.blk_lo;
            acc_hi_nxt = head_item.blk_hi;
          end else begin
            acc_lo_nxt = prod_a[63:0] ^ prod_b[63:0] ^ head_item.blk_lo;
            acc_hi_nxt = prod_a[127:64] ^ prod_b[127:64] ^ head_item.blk_hi;
          end
          if (head_item.last) begin
            state_nxt = ST_RED1;
          end
        end
      end
      ST_RED1: begin
        // 128 -> 64
        prod_r    = clmul64(K6, acc_lo_r);
        r_lo_nxt  = acc_hi_r ^ prod_r[63:0];
        r_hi_nxt  = prod_r[127:64];
        state_nxt = ST_RED2;
      end
      ST_RED2: begin
        // 64 -> 32
        prod_r    = clmul64(K7, r_lo_r & LOW32);
        r_lo_nxt  = prod_r[63:0] ^ s_lo;
        r_hi_nxt  = prod_r[127:64] ^ s_hi;
        state_nxt = ST_RED3;
      end
      ST_RED3: begin
        // Barrett, first product
        prod_r    = clmul64(P2, r_lo_r & LOW32);
        t_nxt     = prod_r[31:0];
        state_nxt = ST_RED4;
      end
      ST_RED4: begin
        prod_r = clmul64(P1, {32'd0, t_r});
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_crc_nxt   = r_lo_r[63:32] ^ prod_r[63:32];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_lo_r    <= '0;
      acc_hi_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_lo_r    <= acc_lo_nxt;
      acc_hi_r    <= acc_hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_lo_r    <= r_lo_nxt;
    r_hi_r    <= r_hi_nxt;
    t_r       <= t_nxt;
    out_crc_r <= out_crc_nxt;
  end

endmodule

/* rtl/crc32c_block_folder_top.sv */
// Top level of the CRC32C block folder
//
//   channel | ports                                   | moves
//   in      | in_valid / in_ready, in_* fields        | one 16-byte block per item
//   out     | out_valid / out_ready, out_crc_out      | one CRC per last block
//
// A block that is not last takes one fold of the accumulator in the back end; a
// last block takes the fold, then four reduction steps through the shared
// carry-less product (128->64, 64->32, two Barrett steps).
// Reset clears the accumulator, queue and result valid flag; no clearing pass.
// A stalled result holds in the output register; the back end then waits in its
// final reduction step while the queue keeps taking items until it fills.
module crc32c_block_folder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_low_word,
  input  logic [63:0] in_data_high_word,
  input  logic [31:0] in_initial_crc,
  input  logic        in_first_block,
  input  logic        in_last_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_crc_out
);
  import cbf_pkg::*;
  `include "crc32c_block_folder_top_macros.svh"

  cbf_item_t      push_item;
  cbf_item_t      head_item;
  cbf_back_stat_t back_stat;
  logic           q_push, q_pop, q_full, q_empty;

  cbf_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_low_word  (in_data_low_word),
    .in_data_high_word (in_data_high_word),
    .in_initial_crc    (in_initial_crc),
    .in_first_block    (in_first_block),
    .in_last_block     (in_last_block),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_item            (push_item)
  );

  cbf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  cbf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_item   (head_item),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .stat        (back_stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_crc_out (out_crc_out)
  );

  `CBF_ASSERT_NOW(a_pop_not_empty, q_pop, !q_empty && back_stat.idle, "pop while empty or busy")
  `CBF_ASSERT_NEXT(a_last_reduces, q_pop && head_item.last, back_stat.reducing, "no reduction")
  `CBF_ASSERT_NEXT(a_push_lands, in_valid && in_ready && !q_pop, !q_empty, "item lost")

endmodule
